### rtl/core/hjc_pkg.sv
`timescale 1ns / 1ps
package hjc_pkg;

   localparam int CP_W            = 21;
   localparam int IDX_W           = 5;
   localparam int NUM_INITIAL     = 19;
   localparam int NUM_MEDIAL      = 21;
   localparam int NUM_FINAL       = 28;
   localparam int HJC_QUEUE_DEPTH = 4;

   localparam logic [15:0]     SYL_BASE    = 16'hAC00;
   localparam logic [CP_W-1:0] VOWEL_FIRST = 21'h0314F;

   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_CONS  = 2'd1;
   localparam logic [1:0] KIND_VOWEL = 2'd2;

   typedef struct packed {
      logic [1:0]       kind;
      logic [IDX_W-1:0] idx;
      logic [CP_W-1:0]  ch;
   } hjc_item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } hjc_q_stat_type;

   localparam logic [15:0] INITIAL_CP [NUM_INITIAL] = '{
      16'h3131, 16'h3132, 16'h3134, 16'h3137, 16'h3138, 16'h3139, 16'h3141, 16'h3142,
      16'h3143, 16'h3145, 16'h3146, 16'h3147, 16'h3148, 16'h3149, 16'h314A, 16'h314B,
      16'h314C, 16'h314D, 16'h314E
   };

   // final index for each initial, zero when it cannot close a syllable
   localparam logic [IDX_W-1:0] FINAL_OF_INITIAL [NUM_INITIAL] = '{
      5'd1, 5'd2, 5'd4, 5'd7, 5'd0, 5'd8, 5'd16, 5'd17, 5'd0, 5'd19,
      5'd20, 5'd21, 5'd22, 5'd0, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27
   };

   localparam logic [IDX_W-1:0] FINAL_STAY [NUM_FINAL] = '{
      5'd0, 5'd0, 5'd0, 5'd1, 5'd0, 5'd4, 5'd4, 5'd0, 5'd0, 5'd8,
      5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd0, 5'd0, 5'd17, 5'd0,
      5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0
   };

   localparam logic [IDX_W-1:0] FINAL_MOVE [NUM_FINAL] = '{
      5'd0, 5'd0, 5'd1, 5'd9, 5'd2, 5'd12, 5'd18, 5'd3, 5'd5, 5'd0,
      5'd6, 5'd7, 5'd9, 5'd16, 5'd17, 5'd18, 5'd6, 5'd7, 5'd9, 5'd9,
      5'd10, 5'd11, 5'd12, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18
   };

   function automatic logic [CP_W-1:0] syllable(input logic [IDX_W-1:0] ini,
                                                input logic [IDX_W-1:0] med,
                                                input logic [IDX_W-1:0] fin);
      logic [8:0]  im;
      logic [15:0] s;
      im = 9'(ini) * 9'd21 + 9'(med);
      s  = SYL_BASE + 16'(im) * 16'd28 + 16'(fin);
      return {5'd0, s};
   endfunction

   // {hit, index}
   function automatic logic [IDX_W:0] find_initial(input logic [CP_W-1:0] ch);
      logic [IDX_W:0] r;
      r = '0;
      for (int i = 0; i < NUM_INITIAL; i++) begin
         if (ch == {5'd0, INITIAL_CP[i]}) r = {1'b1, IDX_W'(i)};
      end
      return r;
   endfunction

   // {ok, merged vowel index}
   function automatic logic [IDX_W:0] merge_vowels(input logic [IDX_W-1:0] a,
                                                   input logic [IDX_W-1:0] b);
      logic [IDX_W:0] r;
      r = '0;
      if (a == 5'd8) begin
         if (b == 5'd0)  r = {1'b1, 5'd9};
         if (b == 5'd1)  r = {1'b1, 5'd10};
         if (b == 5'd20) r = {1'b1, 5'd11};
      end
      if (a == 5'd13) begin
         if (b == 5'd4)  r = {1'b1, 5'd14};
         if (b == 5'd5)  r = {1'b1, 5'd15};
         if (b == 5'd20) r = {1'b1, 5'd16};
      end
      if (a == 5'd18 && b == 5'd20) r = {1'b1, 5'd19};
      return r;
   endfunction

   // double final from current final and new initial, zero if none
   function automatic logic [IDX_W-1:0] merge_finals(input logic [IDX_W-1:0] fin,
                                                     input logic [IDX_W-1:0] ini);
      logic [IDX_W-1:0] d;
      d = '0;
      for (int i = 1; i < NUM_FINAL; i++) begin
         if (FINAL_STAY[i] != '0 && FINAL_STAY[i] == fin && FINAL_MOVE[i] == ini)
            d = IDX_W'(i);
      end
      return d;
   endfunction

endpackage

### rtl/core/hjc_ifs.sv
`timescale 1ns / 1ps
interface hjc_req_if
   import hjc_pkg::*;
();
   logic            valid;
   logic            ready;
   logic [CP_W-1:0] in_char;

   modport source (output valid, output in_char, input ready);
   modport sink   (input valid, input in_char, output ready);
endinterface

interface hjc_rsp_if
   import hjc_pkg::*;
();
   logic            valid;
   logic            ready;
   logic [CP_W-1:0] first_char;
   logic [CP_W-1:0] second_char;
   logic            second_valid;
   logic            erase_last;

   modport source (output valid, output first_char, output second_char,
                   output second_valid, output erase_last, input ready);
   modport sink   (input valid, input first_char, input second_char,
                   input second_valid, input erase_last, output ready);
endinterface

### rtl/core/hjc_front.sv
`timescale 1ns / 1ps
module hjc_front
   import hjc_pkg::*;
(
   hjc_req_if.sink      req_bus,
   input  logic         q_full,
   output logic         push,
   output hjc_item_type item
);

   logic [IDX_W:0]  ini_hit;
   logic            is_vowel;
   logic [CP_W-1:0] voff;

   assign req_bus.ready = !q_full;
   assign push          = req_bus.valid && !q_full;

   always_comb begin
      ini_hit  = find_initial(req_bus.in_char);
      voff     = req_bus.in_char - VOWEL_FIRST;
      is_vowel = (req_bus.in_char >= VOWEL_FIRST) &&
                 (req_bus.in_char < VOWEL_FIRST + CP_W'(NUM_MEDIAL));
      item.ch  = req_bus.in_char;
      if (ini_hit[IDX_W]) begin
         item.kind = KIND_CONS;
         item.idx  = ini_hit[IDX_W-1:0];
      end else if (is_vowel) begin
         item.kind = KIND_VOWEL;
         item.idx  = voff[IDX_W-1:0];
      end else begin
         item.kind = KIND_OTHER;
         item.idx  = '0;
      end
   end

endmodule

### rtl/core/hjc_queue.sv
`timescale 1ns / 1ps
module hjc_queue
   import hjc_pkg::*;
#(
   parameter int Depth = HJC_QUEUE_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  hjc_item_type   push_item,
   input  logic           pop,
   output hjc_item_type   head_item,
   output hjc_q_stat_type stat
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   hjc_item_type  mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CntW'(Depth));
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_item;
   end

endmodule

### rtl/core/hjc_back.sv
`timescale 1ns / 1ps
module hjc_back
   import hjc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  hjc_item_type   item,
   input  hjc_q_stat_type q_stat,
   output logic           pop,
   hjc_rsp_if.source      rsp_bus
);

   logic [IDX_W-1:0] ini_ff, ini_in;
   logic [IDX_W-1:0] med_ff, med_in;
   logic [IDX_W-1:0] fin_ff, fin_in;
   logic             comp_ff, comp_in;

   logic             valid_ff, valid_in;
   logic [CP_W-1:0]  first_ff, first_in;
   logic [CP_W-1:0]  second_ff, second_in;
   logic             sv_ff, sv_in;
   logic             del_ff, del_in;

   logic [IDX_W-1:0] med_idx;
   logic [IDX_W-1:0] new_fin;
   logic [IDX_W-1:0] dbl_fin;
   logic [IDX_W:0]   vmerge;
   logic [IDX_W-1:0] mv;

   assign pop                  = !q_stat.empty && (!valid_ff || rsp_bus.ready);
   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.first_char   = first_ff;
   assign rsp_bus.second_char  = second_ff;
   assign rsp_bus.second_valid = sv_ff;
   assign rsp_bus.erase_last   = del_ff;

   always_comb begin
      med_idx   = med_ff - 5'd1;
      new_fin   = FINAL_OF_INITIAL[item.idx];
      dbl_fin   = merge_finals(fin_ff, item.idx);
      vmerge    = merge_vowels(med_idx, item.idx);
      mv        = FINAL_MOVE[fin_ff];

      ini_in    = ini_ff;
      med_in    = med_ff;
      fin_in    = fin_ff;
      comp_in   = comp_ff;
      first_in  = item.ch;
      second_in = '0;
      sv_in     = 1'b0;
      del_in    = 1'b0;

      unique case (item.kind)
         KIND_CONS: begin
            if (!comp_ff || med_ff == '0 ||
                (fin_ff == '0 && new_fin == '0) ||
                (fin_ff != '0 && dbl_fin == '0)) begin
               ini_in  = item.idx;
               med_in  = '0;
               fin_in  = '0;
               comp_in = 1'b1;
            end else if (fin_ff == '0) begin
               fin_in   = new_fin;
               del_in   = 1'b1;
               first_in = syllable(ini_ff, med_idx, new_fin);
            end else begin
               fin_in   = dbl_fin;
               del_in   = 1'b1;
               first_in = syllable(ini_ff, med_idx, dbl_fin);
            end
         end
         KIND_VOWEL: begin
            if (!comp_ff) begin
               comp_in = 1'b0;
            end else if (med_ff == '0) begin
               med_in   = item.idx + 5'd1;
               del_in   = 1'b1;
               first_in = syllable(ini_ff, item.idx, '0);
            end else if (fin_ff != '0) begin
               // final carries forward into a new syllable
               del_in    = 1'b1;
               first_in  = syllable(ini_ff, med_idx, FINAL_STAY[fin_ff]);
               second_in = syllable(mv, item.idx, '0);
               sv_in     = 1'b1;
               ini_in    = mv;
               med_in    = item.idx + 5'd1;
               fin_in    = '0;
            end else if (vmerge[IDX_W]) begin
               med_in   = vmerge[IDX_W-1:0] + 5'd1;
               del_in   = 1'b1;
               first_in = syllable(ini_ff, vmerge[IDX_W-1:0], '0);
            end else begin
               ini_in  = '0;
               med_in  = '0;
               fin_in  = '0;
               comp_in = 1'b0;
            end
         end
         default: begin
            comp_in = 1'b0;
         end
      endcase

      valid_in = pop || (valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ini_ff   <= '0;
         med_ff   <= '0;
         fin_ff   <= '0;
         comp_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            ini_ff  <= ini_in;
            med_ff  <= med_in;
            fin_ff  <= fin_in;
            comp_ff <= comp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         first_ff  <= first_in;
         second_ff <= second_in;
         sv_ff     <= sv_in;
         del_ff    <= del_in;
      end
   end

endmodule

### rtl/core/hangul_jamo_composer_unit.sv
`timescale 1ns / 1ps
// Two-set Hangul composer: one code point per key in, one result per key out, one item
// per cycle sustained while the result side keeps ready high. The front decodes the key
// (initial consonant, vowel or other) in the cycle it is accepted and writes it into a
// QueueDepth-entry queue; the back pops one entry per cycle while the output register is
// free or being taken, updates the syllable state and loads the output register, so a
// key is registered in the queue and then in the output register. The input stalls only
// when the queue is full, which happens only while the result side holds off ready.
// Results carry up to two characters and a flag to delete the character inserted last.
module hangul_jamo_composer_unit
   import hjc_pkg::*;
#(
   parameter int QueueDepth = HJC_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   hjc_req_if.sink    req_bus,
   hjc_rsp_if.source  rsp_bus
);

   hjc_item_type   push_item;
   hjc_item_type   head_item;
   hjc_q_stat_type q_stat;
   logic           push;
   logic           pop;

   hjc_front u_front (
      .req_bus (req_bus),
      .q_full  (q_stat.full),
      .push    (push),
      .item    (push_item)
   );

   hjc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .stat      (q_stat)
   );

   hjc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .item    (head_item),
      .q_stat  (q_stat),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

   a_accept_fills_queue: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !q_stat.empty)
      else $error("accepted item missing from queue");

   a_queue_drains: assert property (@(posedge clock) disable iff (reset)
      !q_stat.empty && !(rsp_bus.valid && !rsp_bus.ready) |=> rsp_bus.valid)
      else $error("queued item not moved to output");

   a_second_needs_delete: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.second_valid |-> rsp_bus.erase_last)
      else $error("second character without delete");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid && q_stat.empty)
      else $error("reset left items pending");

endmodule
